// ----- sv/hpf_pkg.sv -----
`timescale 1ns / 1ps
package hpf_pkg;

  localparam int NUM_PCT = 4;
  // Total sample count is divided by 100 one byte per stage, most significant first.
  localparam int NDIG = 6;
  localparam int QDEPTH = 4;
  localparam logic [14:0] RANK_DIV = 15'd100;
  // 2^21 / 100 rounded up; exact for any value below 25600.
  localparam logic [14:0] DIV100_MUL = 15'd20972;

  typedef struct packed {
    logic [31:0]                  bin;
    logic [NUM_PCT-1:0][47:0]     lo;
    logic [NUM_PCT-1:0]           exact;
    logic                         last;
  } rank_item_t;

  function automatic logic [6:0] pct_val(input int k);
    case (k)
      0: return 7'd10;
      1: return 7'd50;
      2: return 7'd90;
      default: return 7'd99;
    endcase
  endfunction

  // Quotient of a value below 25600 divided by 100.
  function automatic logic [7:0] div100_q(input logic [14:0] v);
    logic [29:0] p;
    p = 30'(v) * 30'(DIV100_MUL);
    return p[28:21];
  endfunction

  function automatic logic [6:0] div100_r(input logic [14:0] v, input logic [7:0] q);
    logic [14:0] d;
    d = v - 15'(q) * RANK_DIV;
    return d[6:0];
  endfunction

endpackage

// ----- sv/hpf_front.sv -----
`timescale 1ns / 1ps
module hpf_front
  import hpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic        s_tlast,
  input  logic        q_full,
  output logic        q_push,
  output rank_item_t  q_item
);

  logic              sv   [NDIG];
  logic [47:0]       stot [NDIG];
  logic [31:0]       sbin [NDIG];
  logic              slast[NDIG];
  logic [6:0]        srem [NDIG];
  logic [47:0]       squo [NDIG];

  logic              rv;
  rank_item_t        ritem;
  rank_item_t        ritem_next;
  logic              advance;

  assign advance  = !rv || !q_full;
  assign s_tready = advance;
  assign q_push   = rv && !q_full;
  assign q_item   = ritem;

  // Long division of the total by 100, one byte per stage.
  for (genvar g = 0; g < NDIG; g++) begin : g_div
    logic              pv;
    logic [47:0]       ptot;
    logic [31:0]       pbin;
    logic              plast;
    logic [6:0]        prem;
    logic [47:0]       pquo;
    logic [14:0]       dv;
    logic [7:0]        dq;

    if (g == 0) begin : g_first
      assign pv    = s_tvalid;
      assign ptot  = s_tdata[79:32];
      assign pbin  = s_tdata[31:0];
      assign plast = s_tlast;
      assign prem  = 7'd0;
      assign pquo  = 48'd0;
    end else begin : g_rest
      assign pv    = sv[g-1];
      assign ptot  = stot[g-1];
      assign pbin  = sbin[g-1];
      assign plast = slast[g-1];
      assign prem  = srem[g-1];
      assign pquo  = squo[g-1];
    end

    assign dv = {prem, ptot[47-8*g -: 8]};
    assign dq = div100_q(dv);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g] <= 1'b0;
      end else if (advance) begin
        sv[g] <= pv;
      end
      if (advance) begin
        stot[g]  <= ptot;
        sbin[g]  <= pbin;
        slast[g] <= plast;
        srem[g]  <= div100_r(dv, dq);
        squo[g]  <= {pquo[39:0], dq};
      end
    end
  end

  // total*p/100 = q*p + r*p/100 with total = 100*q + r.
  always_comb begin
    logic [14:0] w;
    logic [7:0]  f;
    logic [6:0]  m;
    ritem_next.bin  = sbin[NDIG-1];
    ritem_next.last = slast[NDIG-1];
    for (int k = 0; k < NUM_PCT; k++) begin
      w = 15'(srem[NDIG-1]) * 15'(pct_val(k));
      f = div100_q(w);
      m = div100_r(w, f);
      ritem_next.lo[k]    = 48'(squo[NDIG-1] * 48'(pct_val(k))) + 48'(f);
      ritem_next.exact[k] = (m == 7'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (advance) begin
      rv <= sv[NDIG-1];
    end
    if (advance) begin
      ritem <= ritem_next;
    end
  end

endmodule

// ----- sv/hpf_queue.sv -----
`timescale 1ns / 1ps
module hpf_queue
  import hpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rank_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output rank_item_t head_item
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  rank_item_t      mem [QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   cnt;
  logic            do_pop;

  assign full       = (cnt == CW'(QDEPTH));
  assign head_valid = (cnt != '0);
  assign head_item  = mem[rptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- sv/hpf_back.sv -----
`timescale 1ns / 1ps
module hpf_back
  import hpf_pkg::*;
#(
  parameter int MAX_BINS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] bin_width,
  input  logic        item_valid,
  input  rank_item_t  item,
  output logic        item_ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  localparam int START_W = $clog2(MAX_BINS * 65535 + 1);
  localparam logic [START_W-1:0] START_MAX = START_W'(MAX_BINS * 65535);

  logic [47:0]             running_sum;
  logic [START_W-1:0]      bin_start;
  logic [NUM_PCT-1:0]      found;
  logic [24:0]             fval [NUM_PCT];

  logic [NUM_PCT-1:0]      bank_known;
  logic [24:0]             bank_val [NUM_PCT];
  logic                    pend;
  logic [1:0]              idx;

  logic                    bank_free;
  logic                    take;
  logic [48:0]             upper;
  logic [47:0]             sum_next;
  logic [START_W:0]        start_sum;
  logic [START_W-1:0]      start_next;
  logic [24:0]             val_start;
  logic [24:0]             val_mid;
  logic [24:0]             val_end;
  logic [NUM_PCT-1:0]      found_next;
  logic [24:0]             fval_next [NUM_PCT];
  logic [NUM_PCT-1:0]      end_found;
  logic [24:0]             end_val [NUM_PCT];

  assign bank_free  = !pend || (idx == 2'd3 && m_tready);
  assign item_ready = !item.last || bank_free;
  assign take       = item_valid && item_ready;

  assign upper      = {1'b0, running_sum} + {17'd0, item.bin};
  assign sum_next   = upper[48] ? {48{1'b1}} : upper[47:0];
  assign start_sum  = {1'b0, bin_start} + (START_W + 1)'(bin_width);
  assign start_next = (start_sum > {1'b0, START_MAX}) ? START_MAX : start_sum[START_W-1:0];
  assign val_start  = 25'({bin_start, 1'b0});
  assign val_mid    = val_start + 25'(bin_width);
  assign val_end    = 25'({start_next, 1'b0});

  always_comb begin
    logic [48:0] hi;
    for (int k = 0; k < NUM_PCT; k++) begin
      hi = {1'b0, item.lo[k]} + 49'(!item.exact[k]);
      found_next[k] = found[k];
      fval_next[k]  = fval[k];
      if (!found[k]) begin
        if (item.exact[k] && item.lo[k] == running_sum) begin
          found_next[k] = 1'b1;
          fval_next[k]  = val_start;
        end else if (running_sum <= item.lo[k] && hi <= upper) begin
          found_next[k] = 1'b1;
          fval_next[k]  = val_mid;
        end
      end
      // The end boundary is checked once the last bin has been added.
      end_found[k] = found_next[k] || (item.exact[k] && item.lo[k] == sum_next);
      end_val[k]   = found_next[k] ? fval_next[k] : val_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      bin_start   <= '0;
      found       <= '0;
      pend        <= 1'b0;
      idx         <= '0;
    end else begin
      if (take && item.last) begin
        pend <= 1'b1;
        idx  <= '0;
      end else if (pend && m_tready) begin
        idx <= idx + 1'b1;
        if (idx == 2'd3) begin
          pend <= 1'b0;
        end
      end
      if (take) begin
        if (item.last) begin
          running_sum <= '0;
          bin_start   <= '0;
          found       <= '0;
        end else begin
          running_sum <= sum_next;
          bin_start   <= start_next;
          found       <= found_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < NUM_PCT; k++) begin
        fval[k] <= fval_next[k];
      end
      if (item.last) begin
        bank_known <= end_found;
        for (int k = 0; k < NUM_PCT; k++) begin
          bank_val[k] <= end_val[k];
        end
      end
    end
  end

  assign m_tvalid = pend;
  assign m_tuser  = idx;
  assign m_tlast  = (idx == 2'd3);
  assign m_tdata  = {6'd0, bank_val[idx], bank_known[idx]};

endmodule

// ----- sv/histogram_percentile_finder_core.sv -----
`timescale 1ns / 1ps
// Histogram percentile finder: finds the 10th, 50th, 90th and 99th percentiles.
// Bins enter on the s_ stream, one bin per request, in order; s_tlast marks the
// last bin of a histogram. After that bin the block sends four requests on the
// m_ stream, percentile 0..3 in m_tuser, m_tlast on the fourth. A value is twice
// the percentile in bin_width units, or twice the final boundary if unknown.
// Users must write bin_width on the cfg_ channel while the block is idle; the
// block does not enforce this. Throughput is one bin per cycle while s_tready
// is high: the rank pipeline and the accumulator each take a new bin every
// cycle. m_tvalid rises once the last bin has passed the six division stages,
// a rank stage, the queue and the result bank; four results follow on m_tready.
// A new histogram may stream in while the previous results drain; only its last
// bin waits until the result bank is free.
// If the receiver stalls, the four-entry queue fills and s_tready drops.
// Synchronous reset sets bin_width to 1 and clears all histogram state.
module histogram_percentile_finder_core
  import hpf_pkg::*;
#(
  parameter int MAX_BINS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // bin_value [31:0], total_samples [79:32]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // is_known [0], value_doubled [25:1], zero [31:26]
  output logic [1:0]  m_tuser,   // which_percentile [1:0]
  output logic        m_tlast
);

  logic [15:0] bin_width;
  logic        q_full;
  logic        q_push;
  rank_item_t  q_in;
  logic        h_valid;
  logic        h_ready;
  rank_item_t  h_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width <= 16'd1;
    end else if (cfg_valid) begin
      bin_width <= cfg_data;
    end
  end

  hpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  hpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (h_ready),
    .head_valid (h_valid),
    .head_item  (h_item)
  );

  hpf_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .bin_width  (bin_width),
    .item_valid (h_valid),
    .item       (h_item),
    .item_ready (h_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import hpf_pkg::*;

  localparam int MAX_BINS = 256;
  localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] START_MAX = 64'(MAX_BINS) * 64'd65535;
  localparam logic [63:0] RANK_SCALE = 64'd100;
  localparam logic [3:0][6:0] PCT_OF = {7'd99, 7'd90, 7'd50, 7'd10};
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned MAX_REPORTED = 10;

  typedef enum logic [1:0] {PCT_10, PCT_50, PCT_90, PCT_99} pct_sel_e;
  typedef enum {REQ_BIN, REQ_WIDTH, REQ_DRAIN, REQ_HOLD} req_kind_e;

  typedef struct {
    req_kind_e   kind;
    logic [31:0] cnt;
    logic [47:0] total;
    logic        last;
    logic [15:0] width;
    int unsigned gap;
  } stim_req_t;

  typedef struct packed {
    pct_sel_e    which;
    logic        known;
    logic [24:0] value;
    logic        last;
  } pct_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  stim_req_t   bin_requests [$];
  pct_report_t expected_reports [$];

  // Percentile tracking state for the histogram in flight.
  logic [15:0]        bin_width_model = 16'd1;
  logic [47:0]        run_sum = '0;
  logic [23:0]        bin_start = '0;
  logic [NUM_PCT-1:0] pct_found = '0;
  logic [25:0]        pct_value [NUM_PCT];

  bit          sender_calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  logic        hold_go = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_bins = 0;
  int unsigned n_hists = 0;
  int unsigned n_checked = 0;
  int unsigned widths_written = 0;

  histogram_percentile_finder_core #(.MAX_BINS(MAX_BINS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #200000;
    $display("histogram_percentile_finder_core regression: fail");
    $finish;
  end

  task automatic clear_histogram();
    int k;
    run_sum = '0;
    bin_start = '0;
    pct_found = '0;
    for (k = 0; k < NUM_PCT; k++) pct_value[k] = '0;
  endtask

  task automatic track_bin(input logic [31:0] cnt, input logic [47:0] total, input logic last);
    logic [63:0] lo [NUM_PCT];
    logic [63:0] hi [NUM_PCT];
    logic [63:0] scaled;
    logic [63:0] upper;
    logic [63:0] nxt;
    logic [63:0] edge2;
    pct_report_t rep;
    int k;
    for (k = 0; k < NUM_PCT; k++) begin
      scaled = 64'(total) * 64'(PCT_OF[k]);
      lo[k] = scaled / RANK_SCALE;
      hi[k] = (scaled + RANK_SCALE - 64'd1) / RANK_SCALE;
    end
    // Each pending percentile is tested against this bin before it is added.
    upper = 64'(run_sum) + 64'(cnt);
    edge2 = 64'(bin_start) << 1;
    for (k = 0; k < NUM_PCT; k++) begin
      if (!pct_found[k]) begin
        if (lo[k] == 64'(run_sum) && lo[k] == hi[k]) begin
          pct_found[k] = 1'b1;
          pct_value[k] = edge2[25:0];
        end else if (64'(run_sum) <= lo[k] && hi[k] <= upper) begin
          pct_found[k] = 1'b1;
          pct_value[k] = 26'(edge2 + 64'(bin_width_model));
        end
      end
    end
    run_sum = (upper > SUM_MAX) ? SUM_MAX[47:0] : upper[47:0];
    nxt = 64'(bin_start) + 64'(bin_width_model);
    bin_start = (nxt > START_MAX) ? START_MAX[23:0] : nxt[23:0];
    n_bins++;
    if (last) begin
      edge2 = 64'(bin_start) << 1;
      for (k = 0; k < NUM_PCT; k++) begin
        if (!pct_found[k] && lo[k] == 64'(run_sum) && lo[k] == hi[k]) begin
          pct_found[k] = 1'b1;
          pct_value[k] = edge2[25:0];
        end
        rep.which = pct_sel_e'(k);
        rep.known = pct_found[k];
        rep.value = pct_found[k] ? pct_value[k][24:0] : edge2[24:0];
        rep.last = (rep.which == PCT_99);
        expected_reports.push_back(rep);
      end
      n_hists++;
      clear_histogram();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bin_width_model = 16'd1;
      clear_histogram();
    end else begin
      if (cfg_valid && cfg_ready) begin
        bin_width_model = cfg_data;
        widths_written++;
      end
      if (s_tvalid && s_tready) track_bin(s_tdata[31:0], s_tdata[79:32], s_tlast);
    end
  end

  function automatic int unsigned draw_gap();
    return sender_calm ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic push_bin(input logic [31:0] cnt, input logic [47:0] total, input logic last);
    stim_req_t req;
    req.kind = REQ_BIN;
    req.cnt = cnt;
    req.total = total;
    req.last = last;
    req.width = '0;
    req.gap = draw_gap();
    bin_requests.push_back(req);
  endtask

  task automatic push_ctrl(input req_kind_e kind, input logic [15:0] width);
    stim_req_t req;
    req.kind = kind;
    req.cnt = '0;
    req.total = '0;
    req.last = 1'b0;
    req.width = width;
    req.gap = 0;
    bin_requests.push_back(req);
  endtask

  // Mostly consistent histograms whose bins add up to the total; a few carry
  // an unrelated total or one that drifts from bin to bin.
  task automatic push_random_histogram(input bit single, output int unsigned n);
    logic [31:0] cnt [$];
    logic [63:0] sum;
    logic [47:0] total;
    logic [31:0] c;
    int unsigned style;
    int unsigned i;
    n = single ? 1 : $urandom_range(1, 8);
    style = $urandom_range(0, 9);
    sum = '0;
    for (i = 0; i < n; i++) begin
      case (style)
        0, 1, 2, 3: c = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(0, 15));
        4, 5, 6: c = 32'(10 * $urandom_range(0, 5));
        default: c = $urandom();
      endcase
      cnt.push_back(c);
      sum = sum + 64'(c);
    end
    total = sum[47:0];
    if (style == 8) total = 48'({$urandom(), $urandom()});
    for (i = 0; i < n; i++) begin
      if (style == 9) total = 48'({$urandom(), $urandom()} >> $urandom_range(0, 47));
      push_bin(cnt[i], total, i == n - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned made;
    int unsigned n;
    int ph;
    logic [15:0] w;
    // Directed part at the reset width.
    push_bin(32'd0, 48'd0, 1'b1);
    push_bin(32'd10, 48'd100, 1'b0);
    push_bin(32'd40, 48'd100, 1'b0);
    push_bin(32'd40, 48'd100, 1'b0);
    push_bin(32'd9, 48'd100, 1'b0);
    push_bin(32'd1, 48'd100, 1'b1);
    // The total shrinks on the last bin so the median lands on a bin edge.
    push_bin(32'd5, 48'd1000, 1'b0);
    push_bin(32'd5, 48'd10, 1'b1);
    push_bin('1, '1, 1'b1);
    push_bin(32'd100, 48'd1000, 1'b0);
    push_bin(32'd100, 48'd1000, 1'b1);
    push_bin(32'd1, 48'd7, 1'b0);
    push_bin(32'd2, 48'd7, 1'b0);
    push_bin(32'd3, 48'd7, 1'b0);
    push_bin(32'd1, 48'd7, 1'b1);
    push_ctrl(REQ_WIDTH, 16'd0);
    push_bin(32'd1, 48'd10, 1'b0);
    push_bin(32'd4, 48'd10, 1'b0);
    push_bin(32'd5, 48'd10, 1'b1);
    push_ctrl(REQ_WIDTH, 16'hFFFF);
    push_bin(32'd2, 48'd20, 1'b0);
    push_bin(32'd8, 48'd20, 1'b0);
    push_bin(32'd10, 48'd20, 1'b1);

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: w = 16'd1;
        1: w = 16'd3;
        2: w = 16'($urandom_range(2, 65534));
        3: w = 16'hFFFF;
        default: w = 16'($urandom_range(1, 255));
      endcase
      push_ctrl(REQ_WIDTH, w);
      sender_calm = (ph == 1);
      if (ph == 2) begin
        // Receiver goes quiet while single-bin histograms keep arriving.
        push_ctrl(REQ_HOLD, '0);
        sender_calm = 1'b1;
        repeat (16) push_random_histogram(1'b1, n);
        sender_calm = 1'b0;
      end
      made = 0;
      while (made < 20) begin
        push_random_histogram(1'b0, n);
        made += n;
        if (ph == 3 && made >= 15 && made < 15 + n) push_ctrl(REQ_DRAIN, '0);
      end
    end
  end

  always @(posedge clk) begin
    quiet_cycles <= (expected_reports.size() == 0 && !s_tvalid) ? quiet_cycles + 1 : 0;
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : bin_sender
    stim_req_t req;
    logic sv;
    logic cv;
    logic go;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
      cfg_valid <= 1'b0;
      cfg_data <= '0;
      hold_go <= 1'b0;
      gap_left <= 0;
    end else begin
      sv = s_tvalid && !s_tready;
      cv = cfg_valid && !cfg_ready;
      go = 1'b0;
      if (!sv && !cv) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (bin_requests.size() != 0) begin
          case (bin_requests[0].kind)
            REQ_BIN: begin
              req = bin_requests.pop_front();
              s_tdata <= {req.total, req.cnt};
              s_tlast <= req.last;
              sv = 1'b1;
              gap_left <= req.gap;
            end
            REQ_HOLD: begin
              req = bin_requests.pop_front();
              go = 1'b1;
            end
            default: begin
              // Width writes and pauses wait until the block has gone quiet.
              if (quiet_cycles >= SETTLE_CYCLES) begin
                req = bin_requests.pop_front();
                if (req.kind == REQ_WIDTH) begin
                  cfg_data <= req.width;
                  cv = 1'b1;
                end
              end
            end
          endcase
        end
      end
      s_tvalid <= sv;
      cfg_valid <= cv;
      hold_go <= go;
    end
  end

  always @(posedge clk) begin : result_checker
    pct_report_t want;
    int unsigned w;
    logic bad;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("unexpected result: pct %0d known %0b value %0d last %0b",
                     m_tuser, m_tdata[0], m_tdata[25:1], m_tlast);
        end else begin
          want = expected_reports.pop_front();
          bad = (m_tuser != want.which) || (m_tdata[0] != want.known) ||
                (m_tdata[25:1] != want.value) || (m_tlast != want.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
              $write("result %0d: expected pct %0d known %0b value %0d last %0b",
                     n_checked, want.which, want.known, want.value, want.last);
              $display(", got pct %0d known %0b value %0d last %0b",
                       m_tuser, m_tdata[0], m_tdata[25:1], m_tlast);
            end
          end
        end
        // Every third stretch of forty results runs without receiver stalls.
        w = (((n_checked / 40) % 3) == 2) ? 0 : $urandom_range(0, 3);
      end else if (w != 0) begin
        w = w - 1;
      end
      rx_wait <= w;
      m_tready <= (w == 0) && (hold_left == 0);
    end
  end

  initial begin : run_end
    wait (rst == 1'b0);
    @(posedge clk);
    while (bin_requests.size() != 0 || s_tvalid || cfg_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Streamed %0d bins in %0d histograms and checked %0d percentile results.",
             n_bins, n_hists, n_checked);
    $display("Bin width set %0d times, from 0 to 65535, with one long receiver hold-off.",
             widths_written);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("histogram_percentile_finder_core regression: pass");
    end else begin
      $display("histogram_percentile_finder_core regression: fail");
    end
    $finish;
  end

endmodule
